FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Every macro samples on clk and stays quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge out of reset.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/rrs_pkg.sv
// Shared types and constants of the round-robin slice scheduler.
// No dependencies; the interfaces, controller, datapath, core and testbench import it.
package rrs_pkg;

	localparam int ID_W      = 8;
	localparam int JOB_TIME_W = 16;
	localparam int QUANTUM_W = 16;
	localparam int SLICE_W   = 16;
	localparam int JOBS_W    = 5;
	localparam int STATUS_W  = 3;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

	localparam logic OP_ENQUEUE  = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED     = 3'd0,
		ST_FULL_DROPPED = 3'd1,
		ST_REQUEUED     = 3'd2,
		ST_COMPLETED    = 3'd3,
		ST_EMPTY        = 3'd4
	} status_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept_enq;
		logic accept_deq;
		logic finish_deq;
	} rrs_ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic full;
		logic empty;
	} rrs_sts_t;

endpackage

FILE: rtl/rrs_cmd_if.sv
// Command channel of the slice scheduler: valid/ready plus one item.
// Depends on rrs_pkg for field widths.
interface rrs_cmd_if import rrs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [ID_W-1:0]       job_id;
	logic [JOB_TIME_W-1:0] job_time;

	modport source (output valid, output operation, output job_id, output job_time,
		input ready);
	modport sink (input valid, input operation, input job_id, input job_time,
		output ready);
endinterface

FILE: rtl/rrs_rsp_if.sv
// Result channel of the slice scheduler: valid/ready plus one result.
// Depends on rrs_pkg for field widths.
interface rrs_rsp_if import rrs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     served_id;
	logic [SLICE_W-1:0]  slice_time;
	logic [SLICE_W-1:0]  time_left;
	logic [JOBS_W-1:0]   jobs_waiting;

	modport source (output valid, output status, output served_id, output slice_time,
		output time_left, output jobs_waiting, input ready);
	modport sink (input valid, input status, input served_id, input slice_time,
		input time_left, input jobs_waiting, output ready);
endinterface

FILE: rtl/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module rrs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/rrs_ctrl.sv
// Controller of the slice scheduler: handshakes and dispatch sequencing.
// Depends on rrs_pkg for the command and status structs.
module rrs_ctrl import rrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     cmd_operation,
	output logic     cmd_ready,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	input  rrs_sts_t sts,
	output rrs_ctl_t ctl
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	always_comb begin
		out_free       = !rsp_valid_q || rsp_ready;
		cmd_ready      = (state_q == S_IDLE) && out_free;
		accept         = cmd_valid && cmd_ready;
		ctl.accept_enq = accept && (cmd_operation == OP_ENQUEUE);
		ctl.accept_deq = accept && (cmd_operation == OP_DISPATCH);
		ctl.finish_deq = (state_q == S_READ) && out_free;
	end

	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.accept_enq || ctl.finish_deq || (ctl.accept_deq && sts.empty)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// wait in S_READ for the head entry to come out of the registered RAM read
					if (ctl.accept_deq && !sts.empty) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (ctl.finish_deq) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/rrs_datapath.sv
// Datapath of the slice scheduler: job ring, pointers, quantum and result register.
// Depends on rrs_pkg and rrs_ram.
module rrs_datapath import rrs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rrs_ctl_t              ctl,
	output rrs_sts_t              sts,
	input  logic [ID_W-1:0]       cmd_job_id,
	input  logic [JOB_TIME_W-1:0] cmd_job_time,
	input  logic                  quantum_we,
	input  logic [QUANTUM_W-1:0]  quantum_wdata,
	output logic [STATUS_W-1:0]   rsp_status,
	output logic [ID_W-1:0]       rsp_served_id,
	output logic [SLICE_W-1:0]    rsp_slice_time,
	output logic [SLICE_W-1:0]    rsp_time_left,
	output logic [JOBS_W-1:0]     rsp_jobs_waiting
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int CW = (TIME_BITS > QUANTUM_W) ? TIME_BITS : QUANTUM_W;
	localparam int MW = ID_W + TIME_BITS;

	logic [IW-1:0]        head_q, tail_q, head_next, tail_next;
	logic [OW-1:0]        occ_q, occ_inc, occ_dec, jobs_sel;
	logic [QUANTUM_W-1:0] quantum_q;

	logic                 ram_we, ram_re;
	logic [MW-1:0]        ram_wdata, ram_rdata;

	logic [ID_W-1:0]      rd_id;
	logic [TIME_BITS-1:0] rd_time;
	logic [CW-1:0]        ht_c, q_c, left_c;
	logic                 requeue;
	logic [TIME_BITS+JOB_TIME_W-1:0] job_ext;
	logic [OW+JOBS_W-1:0] jobs_ext;

	status_t              status_d;
	logic [ID_W-1:0]      served_d;
	logic [SLICE_W-1:0]   slice_d, left_d;
	logic                 load;

	rrs_ram #(
		.WIDTH (MW),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.full  = (occ_q == OW'(QUEUE_DEPTH));
		sts.empty = (occ_q == '0);

		head_next = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_next = (tail_q == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
		occ_inc   = occ_q + 1'b1;
		occ_dec   = occ_q - 1'b1;

		rd_id   = ram_rdata[MW-1:TIME_BITS];
		rd_time = ram_rdata[TIME_BITS-1:0];
		ht_c    = CW'(rd_time);
		q_c     = CW'(quantum_q);
		requeue = ht_c > q_c;
		left_c  = ht_c - q_c;

		// keep the low TIME_BITS of the incoming run time
		job_ext = {{TIME_BITS{1'b0}}, cmd_job_time};

		ram_re    = ctl.accept_deq && !sts.empty;
		ram_we    = (ctl.accept_enq && !sts.full) || (ctl.finish_deq && requeue);
		ram_wdata = ctl.finish_deq ? {rd_id, left_c[TIME_BITS-1:0]}
			: {cmd_job_id, job_ext[TIME_BITS-1:0]};

		load     = ctl.accept_enq || ctl.finish_deq || (ctl.accept_deq && sts.empty);
		served_d = '0;
		slice_d  = '0;
		left_d   = '0;
		jobs_sel = occ_q;
		if (ctl.finish_deq) begin
			status_d = requeue ? ST_REQUEUED : ST_COMPLETED;
			served_d = rd_id;
			slice_d  = requeue ? quantum_q : ht_c[SLICE_W-1:0];
			left_d   = requeue ? left_c[SLICE_W-1:0] : '0;
			jobs_sel = requeue ? occ_q : occ_dec;
		end else if (ctl.accept_enq) begin
			status_d = sts.full ? ST_FULL_DROPPED : ST_ACCEPTED;
			jobs_sel = sts.full ? occ_q : occ_inc;
		end else begin
			status_d = ST_EMPTY;
		end
		jobs_ext = {{JOBS_W{1'b0}}, jobs_sel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			quantum_q <= QUANTUM_RESET;
		end else begin
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
			if (ctl.accept_enq && !sts.full) begin
				tail_q <= tail_next;
				occ_q  <= occ_inc;
			end
			if (ctl.finish_deq) begin
				head_q <= head_next;
				// requeue keeps the count: one job out at the head, one back at the tail
				if (requeue) begin
					tail_q <= tail_next;
				end else begin
					occ_q <= occ_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status       <= status_d;
			rsp_served_id    <= served_d;
			rsp_slice_time   <= slice_d;
			rsp_time_left    <= left_d;
			rsp_jobs_waiting <= jobs_ext[JOBS_W-1:0];
		end
	end

endmodule

FILE: rtl/round_robin_slice_scheduler_core.sv
// Round-robin time-slice scheduler. An enqueue beat on cmd stores a job at the tail
// of a QUEUE_DEPTH-entry ring (or reports it dropped when full); a dispatch beat
// serves the head job for at most one quantum and requeues it if time is left.
// Every command beat yields one result beat on rsp. An enqueue, or a dispatch on an
// empty ring, loads its result straight into the output register; a dispatch of a
// job passes the registered RAM read, then compare, subtract and requeue. Results
// sit in an output register, so a new command is taken as the pending result leaves.
// The quantum register resets to 10 and is written through quantum_we/quantum_wdata.
// Depends on rrs_pkg, rrs_cmd_if, rrs_rsp_if, rrs_ram, rrs_ctrl and rrs_datapath.
module round_robin_slice_scheduler_core import rrs_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rrs_cmd_if.sink              cmd,
	rrs_rsp_if.source            rsp,
	input  logic                 quantum_we,
	input  logic [QUANTUM_W-1:0] quantum_wdata
);

	`include "assert_macros.svh"

	localparam logic [JOBS_W-1:0] DEPTH_JOBS = JOBS_W'(QUEUE_DEPTH);

	rrs_ctl_t ctl;
	rrs_sts_t sts;

	rrs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd.valid),
		.cmd_operation (cmd.operation),
		.cmd_ready     (cmd.ready),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.sts           (sts),
		.ctl           (ctl)
	);

	rrs_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.cmd_job_id       (cmd.job_id),
		.cmd_job_time     (cmd.job_time),
		.quantum_we       (quantum_we),
		.quantum_wdata    (quantum_wdata),
		.rsp_status       (rsp.status),
		.rsp_served_id    (rsp.served_id),
		.rsp_slice_time   (rsp.slice_time),
		.rsp_time_left    (rsp.time_left),
		.rsp_jobs_waiting (rsp.jobs_waiting)
	);

	`ASSERT_NEVER(a_full_and_empty, sts.full && sts.empty, "ring reports full and empty")
	`ASSERT_RST(a_enq_result_next, cmd.valid && cmd.ready && cmd.operation == OP_ENQUEUE |=> rsp.valid, "enqueue beat gave no result")
	`ASSERT_RST(a_empty_count, rsp.valid && rsp.status == ST_EMPTY |-> rsp.jobs_waiting == '0, "empty result with jobs waiting")
	`ASSERT_RST(a_full_count, rsp.valid && rsp.status == ST_FULL_DROPPED |-> rsp.jobs_waiting == DEPTH_JOBS, "drop reported below full")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_slice_scheduler_core: a ring model predicts each result beat.
// Depends on rrs_pkg, rrs_cmd_if, rrs_rsp_if and the scheduler core RTL.
module tb_top;
	import rrs_pkg::*;

	localparam int RING_DEPTH  = 16;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     served_id;
		logic [SLICE_W-1:0]  slice_time;
		logic [SLICE_W-1:0]  time_left;
		logic [JOBS_W-1:0]   jobs_waiting;
	} sched_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 quantum_we;
	logic [QUANTUM_W-1:0] quantum_wdata;

	rrs_cmd_if cmd_ch ();
	rrs_rsp_if rsp_ch ();

	round_robin_slice_scheduler_core #(
		.QUEUE_DEPTH (RING_DEPTH),
		.TIME_BITS   (JOB_TIME_W)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.rsp           (rsp_ch),
		.quantum_we    (quantum_we),
		.quantum_wdata (quantum_wdata)
	);

	// Scheduler model state
	logic [ID_W-1:0]       ring_id   [RING_DEPTH];
	logic [JOB_TIME_W-1:0] ring_time [RING_DEPTH];
	logic [3:0]            ring_head = '0;
	logic [3:0]            ring_tail = '0;
	logic [JOBS_W-1:0]     ring_count = '0;
	logic [QUANTUM_W-1:0]  cur_quantum = QUANTUM_RESET;

	sched_result_t expected_results [$];

	bit cmd_idle_en = 1'b1;
	bit rsp_idle_en = 1'b1;
	int rsp_hold_cycles = 0;
	int err_count = 0;
	int cmd_beats = 0;
	int rsp_beats = 0;
	int status_seen [5] = '{default: 0};
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic sched_result_t predict_slice(input logic op, input logic [ID_W-1:0] id,
		input logic [JOB_TIME_W-1:0] jt);
		sched_result_t r;
		logic [ID_W-1:0] hid;
		logic [JOB_TIME_W-1:0] ht;
		r = '0;
		if (op == OP_ENQUEUE) begin
			if (ring_count >= JOBS_W'(RING_DEPTH)) begin
				r.status = ST_FULL_DROPPED;
			end else begin
				ring_id[ring_tail] = id;
				ring_time[ring_tail] = jt;
				ring_tail = ring_tail + 4'd1;
				ring_count = ring_count + 1'b1;
				r.status = ST_ACCEPTED;
			end
		end else if (ring_count == '0) begin
			r.status = ST_EMPTY;
		end else begin
			// Pop the head before any requeue, so a requeue always finds room
			hid = ring_id[ring_head];
			ht = ring_time[ring_head];
			ring_head = ring_head + 4'd1;
			ring_count = ring_count - 1'b1;
			r.served_id = hid;
			if (ht > cur_quantum) begin
				r.slice_time = cur_quantum;
				r.time_left = ht - cur_quantum;
				ring_id[ring_tail] = hid;
				ring_time[ring_tail] = ht - cur_quantum;
				ring_tail = ring_tail + 4'd1;
				ring_count = ring_count + 1'b1;
				r.status = ST_REQUEUED;
			end else begin
				r.slice_time = ht;
				r.status = ST_COMPLETED;
			end
		end
		r.jobs_waiting = ring_count;
		return r;
	endfunction

	function automatic logic [JOB_TIME_W-1:0] pick_job_time(input logic [QUANTUM_W-1:0] q);
		int v;
		v = 0;
		case ($urandom_range(0, 4))
			0: v = $urandom_range(0, 3);
			1: v = $urandom_range(0, 4 * int'(q));
			2: v = $urandom;
			3: v = int'(q) + int'($urandom_range(0, 2)) - 1;
			default: v = $urandom_range(0, 64);
		endcase
		return v[JOB_TIME_W-1:0];
	endfunction

	task automatic send_cmd(input logic op, input logic [ID_W-1:0] id,
		input logic [JOB_TIME_W-1:0] jt);
		int gap;
		gap = cmd_idle_en ? int'($urandom_range(0, 7)) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.operation = op;
		cmd_ch.job_id = id;
		cmd_ch.job_time = jt;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		expected_results.push_back(predict_slice(op, id, jt));
		cmd_beats++;
	endtask

	// Drop valid and hold until every predicted beat has come back
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
		drain_results();
		@(negedge clk);
		quantum_we = 1'b1;
		quantum_wdata = q;
		@(negedge clk);
		quantum_we = 1'b0;
		cur_quantum = q;
	endtask

	// Max quantum completes every job, so this empties the ring
	task automatic clear_ring();
		set_quantum(16'hFFFF);
		while (ring_count != '0) send_cmd(OP_DISPATCH, 8'($urandom), 16'($urandom));
		drain_results();
	endtask

	task automatic test_reset_state();
		send_cmd(OP_DISPATCH, 8'hFF, 16'hFFFF);
		send_cmd(OP_ENQUEUE, 8'h00, 16'h0000);
		send_cmd(OP_ENQUEUE, 8'hFF, 16'hFFFF);
		send_cmd(OP_ENQUEUE, 8'hA5, 16'd10);
		send_cmd(OP_ENQUEUE, 8'h5A, 16'd11);
		repeat (5) send_cmd(OP_DISPATCH, 8'h00, 16'h0000);
		clear_ring();
	endtask

	task automatic test_zero_quantum();
		set_quantum('0);
		send_cmd(OP_ENQUEUE, 8'h01, 16'd5);
		send_cmd(OP_ENQUEUE, 8'h02, 16'd0);
		repeat (3) send_cmd(OP_DISPATCH, 8'h00, 16'h0000);
		clear_ring();
	endtask

	task automatic test_full_ring();
		set_quantum(QUANTUM_RESET);
		for (int i = 0; i <= RING_DEPTH; i++) send_cmd(OP_ENQUEUE, 8'($urandom),
			16'($urandom_range(0, 40)));
		repeat (2) send_cmd(OP_DISPATCH, 8'h00, 16'h0000);
		clear_ring();
	endtask

	// Receiver holds off while the sender keeps offering beats back to back
	task automatic test_backpressure();
		set_quantum(16'd1);
		cmd_idle_en = 1'b0;
		rsp_hold_cycles = 300;
		for (int i = 0; i < 30; i++) begin
			send_cmd(($urandom_range(0, 99) < 65) ? OP_ENQUEUE : OP_DISPATCH, 8'($urandom),
				pick_job_time(cur_quantum));
		end
		cmd_idle_en = 1'b1;
		clear_ring();
	endtask

	task automatic test_random_traffic(input int n_items, input logic [QUANTUM_W-1:0] q,
		input bit src_idle, input bit dst_idle);
		int enq_pct;
		logic op;
		set_quantum(q);
		cmd_idle_en = src_idle;
		rsp_idle_en = dst_idle;
		for (int i = 0; i < n_items; i++) begin
			// Alternate fill-heavy and dispatch-heavy stretches to sweep the ring level
			enq_pct = ((i / 40) % 2 == 0) ? 70 : 35;
			op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DISPATCH;
			send_cmd(op, 8'($urandom), pick_job_time(q));
		end
		clear_ring();
		cmd_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
	endtask

	initial begin : rsp_sink
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				gap = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else begin
				gap = rsp_idle_en ? int'($urandom_range(0, 7)) : 0;
			end
			if (gap > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : check_results
		sched_result_t exp_r;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			rsp_beats++;
			if (rsp_ch.status < 3'd5) status_seen[rsp_ch.status]++;
			if (expected_results.size() == 0) begin
				$error("result beat with none expected: status %0d id %0d", rsp_ch.status,
					rsp_ch.served_id);
				err_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
					err_count++;
				end
				if (rsp_ch.served_id !== exp_r.served_id) begin
					$error("served_id: expected %0d, got %0d", exp_r.served_id,
						rsp_ch.served_id);
					err_count++;
				end
				if (rsp_ch.slice_time !== exp_r.slice_time) begin
					$error("slice_time: expected %0d, got %0d", exp_r.slice_time,
						rsp_ch.slice_time);
					err_count++;
				end
				if (rsp_ch.time_left !== exp_r.time_left) begin
					$error("time_left: expected %0d, got %0d", exp_r.time_left,
						rsp_ch.time_left);
					err_count++;
				end
				if (rsp_ch.jobs_waiting !== exp_r.jobs_waiting) begin
					$error("jobs_waiting: expected %0d, got %0d", exp_r.jobs_waiting,
						rsp_ch.jobs_waiting);
					err_count++;
				end
			end
		end
	end

	// Count cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : main
		arst_n = 1'b0;
		quantum_we = 1'b0;
		quantum_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_ENQUEUE;
		cmd_ch.job_id = '0;
		cmd_ch.job_time = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_zero_quantum();
		test_full_ring();
		test_backpressure();
		test_random_traffic(400, 16'd1, 1'b1, 1'b1);
		test_random_traffic(500, QUANTUM_RESET, 1'b0, 1'b0);
		test_random_traffic(300, 16'hFFFF, 1'b1, 1'b0);
		test_random_traffic(500, 16'($urandom_range(2, 200)), 1'b1, 1'b1);
		test_random_traffic(300, 16'($urandom_range(1, 65535)), 1'b0, 1'b1);

		drain_results();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d result beats never arrived", expected_results.size());
			err_count++;
		end
		$display("Run covered %0d command beats and %0d result beats over several quanta",
			cmd_beats, rsp_beats);
		$display("  accepted %0d, dropped %0d, requeued %0d, completed %0d, empty %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
